### rtl/core/vau_pkg.sv
// Package for the three-dimensional vector arithmetic unit.
// Holds the item types, the mode codes, the front-to-back record and the saturation helper.
// Has no dependencies; every other file but vau_chan_if imports it.
package vau_pkg;

	localparam int VEC_LEN   = 3;
	localparam int NUM_MUL   = 6;
	localparam int DIV_STEPS = 48;

	localparam logic [2:0] MODE_ADD   = 3'd0;
	localparam logic [2:0] MODE_SUB   = 3'd1;
	localparam logic [2:0] MODE_DOT   = 3'd2;
	localparam logic [2:0] MODE_SCALE = 3'd3;
	localparam logic [2:0] MODE_DIV   = 3'd4;
	localparam logic [2:0] MODE_CROSS = 3'd5;

	localparam logic signed [65:0] Q_MAX_W = 66'sd2147483647;
	localparam logic signed [65:0] Q_MIN_W = -66'sd2147483648;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] scalar;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] res_x;
		logic signed [31:0] res_y;
		logic signed [31:0] res_z;
		logic signed [31:0] dot_value;
		logic               divide_error;
		logic               saturated;
	} rsp_t;

	// Decoded item passed from the front end through the queue.
	typedef struct packed {
		logic [2:0]                      mode;
		logic                            div_zero;
		logic [VEC_LEN-1:0][31:0]        a;
		logic [VEC_LEN-1:0][31:0]        b;
		logic [31:0]                     scalar;
		logic [NUM_MUL-1:0][31:0]        ma;
		logic [NUM_MUL-1:0][31:0]        mb;
	} fe_t;

	typedef struct packed {
		logic        clip;
		logic [31:0] val;
	} sat_t;

	// Clips a wide signed value to the Q16.16 range and reports the clip.
	function automatic sat_t sat_q(input logic signed [65:0] v);
		sat_t r;
		r.clip = 1'b0;
		r.val  = v[31:0];
		if (v > Q_MAX_W) begin
			r.clip = 1'b1;
			r.val  = 32'h7fff_ffff;
		end else if (v < Q_MIN_W) begin
			r.clip = 1'b1;
			r.val  = 32'h8000_0000;
		end
		return r;
	endfunction

endpackage

### rtl/core/vau_chan_if.sv
// Valid/ready channel interface used for both the operand and the result streams.
// The payload type is a parameter; the unit uses vau_pkg::cmd_t and vau_pkg::rsp_t.
interface vau_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/vector3_arithmetic_unit.sv
// Three-dimensional vector arithmetic unit, top level.
// Depends on vau_pkg, vau_chan_if, vau_front, vau_queue and vau_back.
//
// Usage: operand items arrive on the cmd channel (valid/ready, payload cmd_t)
// and one result item per operand item leaves on the rsp channel (payload
// rsp_t), in order. Modes are add, subtract, dot, scale, divide and cross;
// all values are signed Q16.16 and every result saturates.
// Throughput: one item per cycle in every mode while rsp.ready is high.
// Every item runs through the same pipeline: an input register, the queue,
// a multiply stage, 48 stages of a one-bit-per-stage divider and an output
// register.
// Stalls: while rsp.valid is high and rsp.ready is low the back end holds;
// the front end keeps taking items until the queue of QUEUE_DEPTH items
// and its input register are full, then drops cmd.ready.
// Reset: arst_n clears all valid bits and queue pointers; no items are held
// and the unit is ready in the first cycle after reset.
module vector3_arithmetic_unit import vau_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	vau_chan_if.sink   cmd,
	vau_chan_if.source rsp
);

	fe_t  fe_data;
	logic fe_valid;
	logic fe_ready;
	fe_t  q_data;
	logic q_valid;
	logic q_ready;

	vau_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.fe_data  (fe_data),
		.fe_valid (fe_valid),
		.fe_ready (fe_ready)
	);

	vau_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (fe_data),
		.wr_valid (fe_valid),
		.wr_ready (fe_ready),
		.rd_data  (q_data),
		.rd_valid (q_valid),
		.rd_ready (q_ready)
	);

	vau_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_data),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.rsp     (rsp)
	);

endmodule

### rtl/core/vau_front.sv
// Front end: takes operand items, decodes the mode and routes multiplier operands.
// Depends on vau_pkg and vau_chan_if.
module vau_front import vau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	vau_chan_if.sink cmd,
	output fe_t   fe_data,
	output logic  fe_valid,
	input  logic  fe_ready
);

	fe_t  dec;
	fe_t  fe_s1;
	logic valid_s1;

	assign cmd.ready = !valid_s1 || fe_ready;
	assign fe_valid  = valid_s1;
	assign fe_data   = fe_s1;

	// Operand routing for the six multipliers, chosen by mode.
	always_comb begin
		dec          = '0;
		dec.mode     = cmd.data.mode;
		dec.div_zero = (cmd.data.scalar == 32'sd0);
		dec.a[0]     = cmd.data.a_x;
		dec.a[1]     = cmd.data.a_y;
		dec.a[2]     = cmd.data.a_z;
		dec.b[0]     = cmd.data.b_x;
		dec.b[1]     = cmd.data.b_y;
		dec.b[2]     = cmd.data.b_z;
		dec.scalar   = cmd.data.scalar;
		case (cmd.data.mode)
			MODE_DOT: begin
				dec.ma[0] = cmd.data.a_x;  dec.mb[0] = cmd.data.b_x;
				dec.ma[2] = cmd.data.a_y;  dec.mb[2] = cmd.data.b_y;
				dec.ma[4] = cmd.data.a_z;  dec.mb[4] = cmd.data.b_z;
			end
			MODE_SCALE: begin
				dec.ma[0] = cmd.data.a_x;  dec.mb[0] = cmd.data.scalar;
				dec.ma[2] = cmd.data.a_y;  dec.mb[2] = cmd.data.scalar;
				dec.ma[4] = cmd.data.a_z;  dec.mb[4] = cmd.data.scalar;
			end
			MODE_CROSS: begin
				dec.ma[0] = cmd.data.a_y;  dec.mb[0] = cmd.data.b_z;
				dec.ma[1] = cmd.data.a_z;  dec.mb[1] = cmd.data.b_y;
				dec.ma[2] = cmd.data.a_z;  dec.mb[2] = cmd.data.b_x;
				dec.ma[3] = cmd.data.a_x;  dec.mb[3] = cmd.data.b_z;
				dec.ma[4] = cmd.data.a_x;  dec.mb[4] = cmd.data.b_y;
				dec.ma[5] = cmd.data.a_y;  dec.mb[5] = cmd.data.b_x;
			end
			default: begin
			end
		endcase
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			fe_s1 <= dec;
		end
	end

endmodule

### rtl/core/vau_queue.sv
// Small FIFO between the front end and the execution back end.
// Depends on vau_pkg for the item record.
module vau_queue import vau_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  fe_t  wr_data,
	input  logic wr_valid,
	output logic wr_ready,
	output fe_t  rd_data,
	output logic rd_valid,
	input  logic rd_ready
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	fe_t           mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### rtl/core/vau_back.sv
// Back end: multipliers, result reduction with saturation, a pipelined divider and
// the output register. Depends on vau_pkg and vau_chan_if.
module vau_back import vau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  fe_t  q_data,
	input  logic q_valid,
	output logic q_ready,
	vau_chan_if.source rsp
);

	typedef struct packed {
		logic [2:0]               mode;
		logic                     dz;
		rsp_t                     res;
		logic [31:0]              dv;
		logic [VEC_LEN-1:0]       neg;
		logic [VEC_LEN-1:0][31:0] rem;
		logic [VEC_LEN-1:0][47:0] nq;
	} dstg_t;

	logic                adv;
	logic                valid_s1;
	logic [2:0]          mode_s1;
	logic                dz_s1;
	logic [31:0]         a_s1    [VEC_LEN];
	logic [31:0]         b_s1    [VEC_LEN];
	logic signed [63:0]  prod_s1 [NUM_MUL];
	logic [31:0]         dabs_s1;
	logic [31:0]         aabs_s1 [VEC_LEN];
	logic [VEC_LEN-1:0]  neg_s1;

	dstg_t                chain_q [DIV_STEPS];
	logic [DIV_STEPS-1:0] chain_vld_q;
	dstg_t                ent;
	rsp_t                 fin;
	rsp_t                 out_q;
	logic                 out_valid_q;

	// One restoring-division step on each lane.
	function automatic dstg_t div_step(input dstg_t s);
		dstg_t       r;
		logic [32:0] t;
		logic        ge;
		r = s;
		for (int l = 0; l < VEC_LEN; l++) begin
			t  = {s.rem[l], s.nq[l][47]};
			ge = (t >= {1'b0, s.dv});
			r.rem[l] = ge ? 32'(t - {1'b0, s.dv}) : t[31:0];
			r.nq[l]  = {s.nq[l][46:0], ge};
		end
		return r;
	endfunction

	assign adv       = !out_valid_q || rsp.ready;
	assign q_ready   = adv;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// Multiply stage and divider operand preparation.
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= q_data.mode;
			dz_s1   <= q_data.div_zero;
			dabs_s1 <= q_data.scalar[31] ? 32'(-q_data.scalar) : q_data.scalar;
			for (int i = 0; i < NUM_MUL; i++) begin
				prod_s1[i] <= $signed(q_data.ma[i]) * $signed(q_data.mb[i]);
			end
			for (int i = 0; i < VEC_LEN; i++) begin
				a_s1[i]    <= q_data.a[i];
				b_s1[i]    <= q_data.b[i];
				aabs_s1[i] <= q_data.a[i][31] ? 32'(-q_data.a[i]) : q_data.a[i];
				neg_s1[i]  <= q_data.a[i][31] ^ q_data.scalar[31];
			end
		end
	end

	// Reduction of the products and sums, with saturation.
	always_comb begin
		logic signed [32:0] sum;
		logic signed [65:0] wide;
		sat_t               sv [VEC_LEN];
		sat_t               dsv;
		sum      = '0;
		wide     = '0;
		ent      = '0;
		ent.mode = mode_s1;
		ent.dz   = dz_s1;
		ent.dv   = dabs_s1;
		ent.neg  = neg_s1;
		for (int l = 0; l < VEC_LEN; l++) begin
			ent.nq[l] = {aabs_s1[l], 16'h0000};
			sv[l]     = '0;
		end
		dsv = '0;
		case (mode_s1)
			MODE_ADD, MODE_SUB: begin
				for (int l = 0; l < VEC_LEN; l++) begin
					if (mode_s1 == MODE_SUB) begin
						sum = $signed({a_s1[l][31], a_s1[l]}) - $signed({b_s1[l][31], b_s1[l]});
					end else begin
						sum = $signed({a_s1[l][31], a_s1[l]}) + $signed({b_s1[l][31], b_s1[l]});
					end
					sv[l] = sat_q(66'(sum));
				end
			end
			MODE_DOT: begin
				wide = 66'(prod_s1[0]) + 66'(prod_s1[2]) + 66'(prod_s1[4]);
				dsv  = sat_q(wide >>> 16);
			end
			MODE_SCALE: begin
				for (int l = 0; l < VEC_LEN; l++) begin
					wide  = 66'(prod_s1[2*l]);
					sv[l] = sat_q(wide >>> 16);
				end
			end
			MODE_CROSS: begin
				for (int l = 0; l < VEC_LEN; l++) begin
					wide  = 66'(prod_s1[2*l]) - 66'(prod_s1[2*l+1]);
					sv[l] = sat_q(wide >>> 16);
				end
			end
			default: begin
			end
		endcase
		ent.res.res_x        = sv[0].val;
		ent.res.res_y        = sv[1].val;
		ent.res.res_z        = sv[2].val;
		ent.res.dot_value    = dsv.val;
		ent.res.divide_error = (mode_s1 == MODE_DIV) && dz_s1;
		ent.res.saturated    = sv[0].clip | sv[1].clip | sv[2].clip | dsv.clip;
	end

	// Divider pipeline; other results ride along unchanged.
	always_ff @(posedge clk) begin
		if (adv) begin
			chain_q[0] <= div_step(ent);
			for (int k = 1; k < DIV_STEPS; k++) begin
				chain_q[k] <= div_step(chain_q[k-1]);
			end
		end
	end

	// Final sign and saturation of the quotients.
	always_comb begin
		logic signed [48:0] qv;
		sat_t               qs [VEC_LEN];
		dstg_t              last;
		last = chain_q[DIV_STEPS-1];
		fin  = last.res;
		for (int l = 0; l < VEC_LEN; l++) begin
			qv = $signed({1'b0, last.nq[l]});
			if (last.neg[l]) begin
				qv = -qv;
			end
			qs[l] = sat_q(66'(qv));
		end
		if ((last.mode == MODE_DIV) && !last.dz) begin
			fin.res_x     = qs[0].val;
			fin.res_y     = qs[1].val;
			fin.res_z     = qs[2].val;
			fin.saturated = qs[0].clip | qs[1].clip | qs[2].clip;
		end
	end

	// Valid bits of all stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			chain_vld_q <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= q_valid;
			chain_vld_q <= {chain_vld_q[DIV_STEPS-2:0], valid_s1};
			out_valid_q <= chain_vld_q[DIV_STEPS-1];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= fin;
		end
	end

endmodule

### tb/vector3_arithmetic_unit_test.sv
// Self-checking testbench for the three-dimensional vector arithmetic unit.
// Depends on vau_pkg, vau_chan_if and the unit's RTL; drives operand items and checks results.
// Directed rows first, then random items; untyped results come from a local Q16.16 model.
module vector3_arithmetic_unit_test;
	import vau_pkg::*;

	localparam int RANDOM_ITEMS = 950;
	localparam int CYCLE_LIMIT  = 400000;

	logic clk;
	logic arst_n;
	int   cycle_count;
	bit   failed;
	bit   quiet_phase;
	bit   sending_done;

	vau_chan_if #(.T(cmd_t)) cmd ();
	vau_chan_if #(.T(rsp_t)) rsp ();

	vector3_arithmetic_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd.sink),
		.rsp(rsp.source)
	);

	rsp_t expected_results[$];

	// Directed stimulus: operands plus an optional typed-in result.
	typedef struct {
		cmd_t op;
		bit   has_result;
		rsp_t result;
	} row_t;
	row_t directed_rows[$];

	// Free-running clock.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Clips a wide signed value to Q16.16 and records any clipping.
	function automatic logic signed [31:0] clip_q(input logic signed [127:0] v, inout bit clip);
		if (v > 128'sd2147483647) begin
			clip = 1'b1;
			return 32'sh7fff_ffff;
		end else if (v < -128'sd2147483648) begin
			clip = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// Works out the result for one operand item in Q16.16.
	function automatic rsp_t vector_result(input cmd_t op);
		rsp_t r;
		logic signed [127:0] a[3];
		logic signed [127:0] b[3];
		logic signed [127:0] s;
		logic signed [127:0] acc;
		bit clip;
		clip = 1'b0;
		r = '0;
		a[0] = op.a_x;
		a[1] = op.a_y;
		a[2] = op.a_z;
		b[0] = op.b_x;
		b[1] = op.b_y;
		b[2] = op.b_z;
		s = op.scalar;
		case (op.mode)
			MODE_ADD: begin
				r.res_x = clip_q(a[0] + b[0], clip);
				r.res_y = clip_q(a[1] + b[1], clip);
				r.res_z = clip_q(a[2] + b[2], clip);
			end
			MODE_SUB: begin
				r.res_x = clip_q(a[0] - b[0], clip);
				r.res_y = clip_q(a[1] - b[1], clip);
				r.res_z = clip_q(a[2] - b[2], clip);
			end
			MODE_DOT: begin
				// The exact sum floors the same as the split sum of floors and remainders.
				acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
				r.dot_value = clip_q(acc >>> 16, clip);
			end
			MODE_SCALE: begin
				r.res_x = clip_q((a[0] * s) >>> 16, clip);
				r.res_y = clip_q((a[1] * s) >>> 16, clip);
				r.res_z = clip_q((a[2] * s) >>> 16, clip);
			end
			MODE_DIV: begin
				if (s == 0) begin
					r.divide_error = 1'b1;
				end else begin
					// SystemVerilog signed division truncates toward zero.
					r.res_x = clip_q((a[0] <<< 16) / s, clip);
					r.res_y = clip_q((a[1] <<< 16) / s, clip);
					r.res_z = clip_q((a[2] <<< 16) / s, clip);
				end
			end
			MODE_CROSS: begin
				r.res_x = clip_q((a[1] * b[2] - a[2] * b[1]) >>> 16, clip);
				r.res_y = clip_q((a[2] * b[0] - a[0] * b[2]) >>> 16, clip);
				r.res_z = clip_q((a[0] * b[1] - a[1] * b[0]) >>> 16, clip);
			end
			default: begin
			end
		endcase
		r.saturated = clip;
		return r;
	endfunction

	function automatic cmd_t make_op(input logic [2:0] m, input logic signed [31:0] v,
			input logic signed [31:0] w, input logic signed [31:0] s);
		cmd_t c;
		c.mode = m;
		c.a_x = v;
		c.a_y = v;
		c.a_z = v;
		c.b_x = w;
		c.b_y = w;
		c.b_z = w;
		c.scalar = s;
		return c;
	endfunction

	function automatic rsp_t make_rsp(input logic signed [31:0] x, input logic signed [31:0] d,
			input logic de, input logic sat);
		rsp_t r;
		r.res_x = x;
		r.res_y = x;
		r.res_z = x;
		r.dot_value = d;
		r.divide_error = de;
		r.saturated = sat;
		return r;
	endfunction

	function automatic logic signed [31:0] random_word();
		case ($urandom_range(0, 7))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return 32'($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
			3: return 32'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
			4: return 0;
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_t random_op();
		cmd_t c;
		c.mode = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
			: 3'($urandom_range(MODE_ADD, MODE_CROSS));
		c.a_x = random_word();
		c.a_y = random_word();
		c.a_z = random_word();
		c.b_x = random_word();
		c.b_y = random_word();
		c.b_z = random_word();
		c.scalar = ($urandom_range(0, 9) == 0) ? 32'sd0 : random_word();
		return c;
	endfunction

	// Directed rows: extremes, every mode, divide by zero and unused modes.
	task automatic build_rows();
		row_t row;
		row.has_result = 1'b1;
		row.op = make_op(MODE_ADD, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
		row.result = make_rsp(32'sh7fff_ffff, 0, 1'b0, 1'b1);
		directed_rows.push_back(row);
		row.op = make_op(MODE_ADD, 32'sh8000_0000, 32'sh8000_0000, 0);
		row.result = make_rsp(32'sh8000_0000, 0, 1'b0, 1'b1);
		directed_rows.push_back(row);
		row.op = make_op(MODE_SUB, 32'sh8000_0000, 32'sh7fff_ffff, 0);
		row.result = make_rsp(32'sh8000_0000, 0, 1'b0, 1'b1);
		directed_rows.push_back(row);
		row.op = make_op(MODE_SUB, 32'sh7fff_ffff, 32'sh8000_0000, 0);
		row.result = make_rsp(32'sh7fff_ffff, 0, 1'b0, 1'b1);
		directed_rows.push_back(row);
		row.op = make_op(MODE_DOT, 32'sh0001_0000, 32'sh0002_0000, 0);
		row.result = make_rsp(0, 32'sh0006_0000, 1'b0, 1'b0);
		directed_rows.push_back(row);
		row.op = make_op(MODE_DOT, 32'sh8000_0000, 32'sh8000_0000, 0);
		row.result = make_rsp(0, 32'sh7fff_ffff, 1'b0, 1'b1);
		directed_rows.push_back(row);
		row.op = make_op(MODE_SCALE, 32'sh0003_0000, 0, 32'sh0002_0000);
		row.result = make_rsp(32'sh0006_0000, 0, 1'b0, 1'b0);
		directed_rows.push_back(row);
		row.op = make_op(MODE_DIV, 32'sh0001_0000, 0, 0);
		row.result = make_rsp(0, 0, 1'b1, 1'b0);
		directed_rows.push_back(row);
		row.op = make_op(MODE_DIV, 32'sh8000_0000, 0, 32'sh0000_0001);
		row.result = make_rsp(32'sh8000_0000, 0, 1'b0, 1'b1);
		directed_rows.push_back(row);
		row.op = make_op(3'd6, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
		row.result = make_rsp(0, 0, 1'b0, 1'b0);
		directed_rows.push_back(row);
		row.op = make_op(3'd7, -1, -1, 0);
		row.result = make_rsp(0, 0, 1'b0, 1'b0);
		directed_rows.push_back(row);
		// Remaining rows go to the predictor.
		row.has_result = 1'b0;
		row.op = make_op(MODE_SCALE, -32'sd3, 0, 32'sh0000_8000);
		directed_rows.push_back(row);
		row.op = make_op(MODE_SCALE, 32'sh8000_0000, 0, 32'sh8000_0000);
		directed_rows.push_back(row);
		row.op = make_op(MODE_DIV, -32'sh0007_0000, 0, 32'sh0002_0000);
		directed_rows.push_back(row);
		row.op = make_op(MODE_DIV, 32'sh7fff_ffff, 0, -32'sd1);
		directed_rows.push_back(row);
		row.op = make_op(MODE_DIV, 32'sh8000_0000, 0, 32'sh8000_0000);
		directed_rows.push_back(row);
		row.op = '{MODE_CROSS, 32'sh0001_0000, 0, 0, 0, 32'sh0001_0000, 0, 0};
		directed_rows.push_back(row);
		row.op = '{MODE_CROSS, 0, 0, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 0};
		directed_rows.push_back(row);
		row.op = '{MODE_CROSS, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
			32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 0};
		directed_rows.push_back(row);
		row.op = '{MODE_DOT, -32'sd1, 32'sd1, -32'sd1, 32'sd1, 32'sd1, 32'sd1, 0};
		directed_rows.push_back(row);
	endtask

	// Offers one operand item and waits for it to be taken.
	task automatic send_op(input cmd_t op, input rsp_t result);
		int gap;
		if (!quiet_phase && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.data <= op;
		expected_results.push_back(result);
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
	endtask

	// Stimulus: reset, directed table, then random items.
	initial begin
		cmd_t op;
		failed = 1'b0;
		quiet_phase = 1'b0;
		sending_done = 1'b0;
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.data = '0;
		build_rows();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			send_op(directed_rows[i].op, directed_rows[i].has_result ? directed_rows[i].result
				: vector_result(directed_rows[i].op));
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - 150)
				quiet_phase = 1'b1;
			op = random_op();
			send_op(op, vector_result(op));
		end
		cmd.valid <= 1'b0;
		sending_done = 1'b1;
	end

	// Receiver stalls in random bursts.
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			rsp.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet_phase && $urandom_range(0, 6) == 0) begin
			rsp.ready <= 1'b0;
			stall_left <= $urandom_range(0, 18);
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// Compares each accepted result item with the oldest expectation.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result item %h", $time, rsp.data);
				failed = 1'b1;
			end else begin
				want = expected_results.pop_front();
				if (rsp.data.res_x !== want.res_x) begin
					$display("%0t: res_x expected %h actual %h", $time, want.res_x, rsp.data.res_x);
					failed = 1'b1;
				end
				if (rsp.data.res_y !== want.res_y) begin
					$display("%0t: res_y expected %h actual %h", $time, want.res_y, rsp.data.res_y);
					failed = 1'b1;
				end
				if (rsp.data.res_z !== want.res_z) begin
					$display("%0t: res_z expected %h actual %h", $time, want.res_z, rsp.data.res_z);
					failed = 1'b1;
				end
				if (rsp.data.dot_value !== want.dot_value) begin
					$display("%0t: dot_value expected %h actual %h", $time, want.dot_value,
						rsp.data.dot_value);
					failed = 1'b1;
				end
				if (rsp.data.divide_error !== want.divide_error) begin
					$display("%0t: divide_error expected %b actual %b", $time,
						want.divide_error, rsp.data.divide_error);
					failed = 1'b1;
				end
				if (rsp.data.saturated !== want.saturated) begin
					$display("%0t: saturated expected %b actual %b", $time, want.saturated,
						rsp.data.saturated);
					failed = 1'b1;
				end
			end
		end
	end

	// Ends the run once all items are back and the pipeline has drained, or on timeout.
	initial begin
		cycle_count = 0;
		while (!(sending_done && expected_results.size() == 0) && cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
		end else begin
			repeat (60) @(posedge clk);
			if (!failed && expected_results.size() == 0) begin
				$display("SCOREBOARD CLEAN");
			end else begin
				$display("SCOREBOARD MISMATCH");
			end
		end
		$finish;
	end

endmodule
